[sv/e2q_pkg.sv]
// Shared types, constants and tables for the Euler-to-quaternion converter.
package e2q_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam int ZW = 32;
  localparam int TW = 18;
  localparam int QW = 32;
  localparam int MAGW = 31;
  localparam int RADW = 64;
  localparam int ROOTW = 32;
  localparam int REMW = 34;
  localparam int NUMW = 46;
  localparam int QBITS = 15;

  localparam logic signed [ZW-1:0] FRAC_PI = 32'sd843314857;
  localparam logic signed [ZW-1:0] HALF_PI = 32'sd421657428;
  localparam logic signed [ZW-1:0] X_START = 32'sd163008219;
  localparam logic [QBITS-1:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic flip;
  } hangle_t;

  typedef struct packed {
    hangle_t roll;
    hangle_t pitch;
    hangle_t yaw;
  } front_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/euler_to_quaternion.sv]
// Top level of the Euler-angle to unit-quaternion converter.
// Takes one set of roll, pitch and yaw angles per cycle while nothing stalls and returns one
// unit quaternion per set, in order; the pipeline is fully unrolled, so the sustained rate is
// one transfer per cycle. A result becomes valid after its input transfer has passed the
// input register, the queue, the CORDIC stages (step count capped at 24), the 32-stage
// square root and the 15-stage divider. A stall on the output freezes the pipeline;
// a four-entry queue behind the input register keeps accepting until it fills.
module euler_to_quaternion import e2q_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  angles_t item,
  output logic    quat_valid,
  input  logic    quat_stall,
  output quat_t   quat
);

  logic front_valid;
  front_t front_data;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  front_t q_data;

  assign q_push = front_valid && !q_full;

  e2q_front u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .front_valid(front_valid), .front_data(front_data), .front_stall(q_full)
  );

  e2q_fifo #(.WIDTH($bits(front_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(front_data),
    .pop(q_pop), .pop_data(q_data),
    .full(q_full), .empty(q_empty)
  );

  e2q_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst),
    .q_avail(!q_empty), .q_data(q_data), .pop(q_pop),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat)
  );

  a_no_stall_when_front_empty: assert property (@(posedge clk) disable iff (rst)
    !front_valid |-> !item_stall) else $error("input stalled with empty front register");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue read while empty");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    quat_valid |-> (quat.quat_w <= 16'sd16384) && (quat.quat_w >= -16'sd16384) &&
                   (quat.quat_x <= 16'sd16384) && (quat.quat_x >= -16'sd16384) &&
                   (quat.quat_y <= 16'sd16384) && (quat.quat_y >= -16'sd16384) &&
                   (quat.quat_z <= 16'sd16384) && (quat.quat_z >= -16'sd16384))
    else $error("quaternion component out of unit range");

endmodule

[sv/e2q_front.sv]
// Input register that halves each angle and folds it into the CORDIC range.
module e2q_front import e2q_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  angles_t item,
  output logic    front_valid,
  output front_t  front_data,
  input  logic    front_stall
);

  function automatic hangle_t fold(input logic signed [15:0] a);
    hangle_t h;
    logic signed [ZW-1:0] z;
    z = ZW'(a) <<< 15;
    h.flip = 1'b0;
    h.z = z;
    if (z > HALF_PI) begin
      h.z = z - FRAC_PI;
      h.flip = 1'b1;
    end else if (z < -HALF_PI) begin
      h.z = z + FRAC_PI;
      h.flip = 1'b1;
    end
    return h;
  endfunction

  assign item_stall = front_valid && front_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      front_valid <= 1'b1;
    end else if (!front_stall) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      front_data.roll <= fold(item.roll_angle);
      front_data.pitch <= fold(item.pitch_angle);
      front_data.yaw <= fold(item.yaw_angle);
    end
  end

endmodule

[sv/e2q_fifo.sv]
// Short queue between the front register and the arithmetic pipeline.
module e2q_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CNTW-1:0] count;

  assign full = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/e2q_cordic.sv]
// Pipelined rotation-mode CORDIC giving cosine and sine of one half angle.
module e2q_cordic import e2q_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  hangle_t              ang,
  output logic signed [TW-1:0] cos_val,
  output logic signed [TW-1:0] sin_val
);

  localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  logic signed [ZW-1:0] xs [NS+1];
  logic signed [ZW-1:0] ys [NS+1];
  logic signed [ZW-1:0] zs [NS+1];
  logic flip [NS+1];
  logic signed [ZW-1:0] x_rnd;
  logic signed [ZW-1:0] y_rnd;
  logic signed [TW-1:0] c_rnd;
  logic signed [TW-1:0] s_rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= X_START;
      ys[0] <= '0;
      zs[0] <= ang.z;
      flip[0] <= ang.flip;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = atan_entry(i);
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_I;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_I;
        end
      end
    end
  end

  always_comb begin
    x_rnd = (xs[NS] + 32'sd8192) >>> 14;
    y_rnd = (ys[NS] + 32'sd8192) >>> 14;
    c_rnd = x_rnd[TW-1:0];
    s_rnd = y_rnd[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= flip[NS] ? -c_rnd : c_rnd;
      sin_val <= flip[NS] ? -s_rnd : s_rnd;
    end
  end

endmodule

[sv/e2q_back.sv]
// Arithmetic pipeline: CORDIC, ZYX products, norm square root, division, output register.
module e2q_back import e2q_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_avail,
  input  front_t q_data,
  output logic   pop,
  output logic   quat_valid,
  input  logic   quat_stall,
  output quat_t  quat
);

  localparam int NS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
  localparam int LAT = NS + 56;

  logic en;
  logic [LAT-1:0] vld;

  logic signed [TW-1:0] cr, sr, cp, sp, cy, sy;
  logic signed [TW-1:0] cy_d, sy_d;
  logic signed [2*TW-1:0] crcp, srsp, crsp, srcp;
  logic signed [3*TW-1:0] crcpcy, srspsy, srcpcy, crspsy;
  logic signed [3*TW-1:0] crspcy, srcpsy, crcpsy, srspcy;
  logic signed [3*TW:0] qsum [4];
  logic signed [QW-1:0] qv [4];
  logic signed [QW-1:0] qabs [4];
  logic [MAGW-1:0] mag [4];
  logic neg [4];
  logic [2*MAGW-1:0] sqr [4];
  logic [RADW-1:0] rad_sum;
  logic [MAGW-1:0] sum_mag [4];
  logic sum_neg [4];

  logic [RADW-1:0] sq_rad [33];
  logic [REMW-1:0] sq_rem [33];
  logic [ROOTW-1:0] sq_root [33];
  logic [MAGW-1:0] sq_mag [33][4];
  logic sq_neg [33][4];

  logic [NUMW-1:0] dv_rem [16][4];
  logic [QBITS-1:0] dv_quo [16][4];
  logic [ROOTW-1:0] dv_m [16];
  logic dv_neg [16][4];

  logic [QBITS-1:0] sat [4];
  logic signed [15:0] res [4];

  assign en = !(quat_valid && quat_stall);
  assign pop = q_avail && en;
  assign quat_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pop};
    end
  end

  e2q_cordic #(.STEPS(STEPS)) u_roll (
    .clk(clk), .en(en), .ang(q_data.roll), .cos_val(cr), .sin_val(sr)
  );
  e2q_cordic #(.STEPS(STEPS)) u_pitch (
    .clk(clk), .en(en), .ang(q_data.pitch), .cos_val(cp), .sin_val(sp)
  );
  e2q_cordic #(.STEPS(STEPS)) u_yaw (
    .clk(clk), .en(en), .ang(q_data.yaw), .cos_val(cy), .sin_val(sy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      crcp <= cr * cp;
      srsp <= sr * sp;
      crsp <= cr * sp;
      srcp <= sr * cp;
      cy_d <= cy;
      sy_d <= sy;
      crcpcy <= crcp * cy_d;
      srspsy <= srsp * sy_d;
      srcpcy <= srcp * cy_d;
      crspsy <= crsp * sy_d;
      crspcy <= crsp * cy_d;
      srcpsy <= srcp * sy_d;
      crcpsy <= crcp * sy_d;
      srspcy <= srsp * cy_d;
    end
  end

  always_comb begin
    qsum[0] = (3*TW+1)'(crcpcy) + (3*TW+1)'(srspsy) + 55'sd8192;
    qsum[1] = (3*TW+1)'(srcpcy) - (3*TW+1)'(crspsy) + 55'sd8192;
    qsum[2] = (3*TW+1)'(crspcy) + (3*TW+1)'(srcpsy) + 55'sd8192;
    qsum[3] = (3*TW+1)'(crcpsy) - (3*TW+1)'(srspcy) + 55'sd8192;
    for (int k = 0; k < 4; k++) begin
      qabs[k] = qv[k][QW-1] ? -qv[k] : qv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        qv[k] <= QW'(qsum[k] >>> 14);
        neg[k] <= qv[k][QW-1];
        mag[k] <= qabs[k][MAGW-1:0];
        sqr[k] <= qabs[k][MAGW-1:0] * qabs[k][MAGW-1:0];
        sum_mag[k] <= mag[k];
        sum_neg[k] <= neg[k];
      end
      rad_sum <= RADW'(sqr[0]) + RADW'(sqr[1]) + RADW'(sqr[2]) + RADW'(sqr[3]);
    end
  end

  always_comb begin
    sq_rad[0] = rad_sum;
    sq_rem[0] = '0;
    sq_root[0] = '0;
    for (int k = 0; k < 4; k++) begin
      sq_mag[0][k] = sum_mag[k];
      sq_neg[0][k] = sum_neg[k];
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_sqrt
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    always_comb begin
      rem_sh = {sq_rem[i][REMW-3:0], sq_rad[i][RADW-1:RADW-2]};
      trial = {sq_root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad[i+1] <= {sq_rad[i][RADW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          sq_rem[i+1] <= rem_sh - trial;
          sq_root[i+1] <= {sq_root[i][ROOTW-2:0], 1'b1};
        end else begin
          sq_rem[i+1] <= rem_sh;
          sq_root[i+1] <= {sq_root[i][ROOTW-2:0], 1'b0};
        end
        for (int k = 0; k < 4; k++) begin
          sq_mag[i+1][k] <= sq_mag[i][k];
          sq_neg[i+1][k] <= sq_neg[i][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_m[0] <= sq_root[32];
      for (int k = 0; k < 4; k++) begin
        dv_rem[0][k] <= NUMW'({sq_mag[32][k], 14'd0}) + NUMW'(sq_root[32] >> 1);
        dv_quo[0][k] <= '0;
        dv_neg[0][k] <= sq_neg[32][k];
      end
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int SH = QBITS - 1 - j;
    logic [NUMW-1:0] dsr;
    assign dsr = NUMW'(dv_m[j]) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_m[j+1] <= dv_m[j];
        for (int k = 0; k < 4; k++) begin
          dv_neg[j+1][k] <= dv_neg[j][k];
          if (dv_rem[j][k] >= dsr) begin
            dv_rem[j+1][k] <= dv_rem[j][k] - dsr;
            dv_quo[j+1][k] <= dv_quo[j][k] | (QBITS'(1) << SH);
          end else begin
            dv_rem[j+1][k] <= dv_rem[j][k];
            dv_quo[j+1][k] <= dv_quo[j][k];
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sat[k] = (dv_quo[QBITS][k] > ONE_Q14) ? ONE_Q14 : dv_quo[QBITS][k];
      res[k] = dv_neg[QBITS][k] ? -16'(sat[k]) : 16'(sat[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_m[QBITS] == '0) begin
        quat.quat_w <= 16'(ONE_Q14);
        quat.quat_x <= '0;
        quat.quat_y <= '0;
        quat.quat_z <= '0;
      end else begin
        quat.quat_w <= res[0];
        quat.quat_x <= res[1];
        quat.quat_y <= res[2];
        quat.quat_z <= res[3];
      end
    end
  end

endmodule
